@@ rtl/core/tcs_pkg.sv @@
// shared types and constants for the track current supervisor
`timescale 1ns / 1ps

package tcs_pkg;

    localparam int TICKS_PER_LED_STEP = 10;
    localparam int STEPS_PER_SECOND   = 100;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ACK_CURRENT_LEVEL   = 3'd0,
        CFG_ACK_SENSE_MARGIN    = 3'd1,
        CFG_QUIESCENT_SENSE     = 3'd2,
        CFG_SHORT_CURRENT_LEVEL = 3'd3,
        CFG_SHORT_TIMEOUT       = 3'd4,
        CFG_FLASH_LENGTH        = 3'd5,
        CFG_DIM_LEVEL           = 3'd6,
        CFG_FULL_LEVEL          = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [14:0] ack_current_level;
        logic [11:0] ack_sense_margin;
        logic [11:0] quiescent_sense;
        logic [14:0] short_current_level;
        logic [6:0]  short_timeout;
        logic [15:0] flash_length;
        logic [7:0]  dim_level;
        logic [7:0]  full_level;
    } cfg_t;

    typedef struct packed {
        logic               clear_ack;
        logic [11:0]        sense_reading;
        logic signed [15:0] current_sample;
    } tick_item_t;

    typedef struct packed {
        logic       second_pulse;
        logic [15:0] seconds;
        logic [8:0]  led_level;
        logic        output_enabled;
        logic        ack_released_flag;
        logic        ack_flag;
    } result_t;

endpackage

@@ rtl/core/tcs_cfg_regs.sv @@
// configuration register file
`timescale 1ns / 1ps

module tcs_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tcs_pkg::cfg_t                   cfg
);
    import tcs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ACK_CURRENT_LEVEL:   cfg_next.ack_current_level   = cfg_data[14:0];
                CFG_ACK_SENSE_MARGIN:    cfg_next.ack_sense_margin    = cfg_data[11:0];
                CFG_QUIESCENT_SENSE:     cfg_next.quiescent_sense     = cfg_data[11:0];
                CFG_SHORT_CURRENT_LEVEL: cfg_next.short_current_level = cfg_data[14:0];
                CFG_SHORT_TIMEOUT:       cfg_next.short_timeout       = cfg_data[6:0];
                CFG_FLASH_LENGTH:        cfg_next.flash_length        = cfg_data[15:0];
                CFG_DIM_LEVEL:           cfg_next.dim_level           = cfg_data[7:0];
                CFG_FULL_LEVEL:          cfg_next.full_level          = cfg_data[7:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ack_current_level   <= 15'd600;
            cfg_reg.ack_sense_margin    <= 12'd60;
            cfg_reg.quiescent_sense     <= 12'd0;
            cfg_reg.short_current_level <= 15'd20000;
            cfg_reg.short_timeout       <= 7'd10;
            cfg_reg.flash_length        <= 16'd100;
            cfg_reg.dim_level           <= 8'd16;
            cfg_reg.full_level          <= 8'd255;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/core/tcs_in_stage.sv @@
// input register stage for tick requests
`timescale 1ns / 1ps

module tcs_in_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tcs_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                          item_valid,
    input  logic                          item_take,
    output tcs_pkg::tick_item_t           item
);
    import tcs_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    tick_item_t item_reg;

    assign s_tready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
            valid_next = 1'b1;
        else if (item_take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            item_reg <= tick_item_t'(s_tdata[28:0]);
    end

endmodule

@@ rtl/core/tcs_update.sv @@
// supervisor state update and result register
`timescale 1ns / 1ps

module tcs_update (
    input  logic                rst_n,
    input  logic                clk,
    input  tcs_pkg::cfg_t       cfg,
    input  logic                item_valid,
    output logic                item_take,
    input  tcs_pkg::tick_item_t item,
    output logic                res_valid,
    input  logic                res_ready,
    output tcs_pkg::result_t    res
);
    import tcs_pkg::*;

    localparam logic [4:0] MS_PERIOD    = 5'(TICKS_PER_LED_STEP);
    localparam logic [7:0] TENMS_PERIOD = 8'(STEPS_PER_SECOND);

    logic [15:0] flash_timer_reg, flash_timer_next;
    logic [7:0]  target_reg, target_next;
    logic [8:0]  duty_reg, duty_next;
    logic [3:0]  ms_div_reg, ms_div_next;
    logic [6:0]  tenms_div_reg, tenms_div_next;
    logic [15:0] sec_reg, sec_next;
    logic [7:0]  short_cnt_reg, short_cnt_next;
    logic        ack_seen_reg, ack_seen_next;
    logic        ack_ended_reg, ack_ended_next;
    logic        res_valid_reg;
    result_t     res_reg, res_next;

    logic        ack_detect;
    logic        over_current;
    logic [6:0]  tmo;
    logic [7:0]  tmo8;
    logic [7:0]  short_inc;
    logic [12:0] sense_limit;
    logic [4:0]  ms_inc;
    logic [7:0]  tenms_inc;
    logic [15:0] flash_loaded;
    logic        led_tick;
    logic        pulse;

    assign item_take = item_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        tmo         = (cfg.short_timeout == 7'd0) ? 7'd1 : cfg.short_timeout;
        tmo8        = {1'b0, tmo};
        sense_limit = {1'b0, cfg.quiescent_sense} + {1'b0, cfg.ack_sense_margin};
        ack_detect  = ($signed({item.current_sample[15], item.current_sample})
                       >= $signed({2'b00, cfg.ack_current_level}))
                      || ({1'b0, item.sense_reading} >= sense_limit);
        over_current = $signed({item.current_sample[15], item.current_sample})
                       >= $signed({2'b00, cfg.short_current_level});

        // ack flags, clear applies before this tick's detection
        ack_seen_next  = item.clear_ack ? 1'b0 : ack_seen_reg;
        ack_ended_next = item.clear_ack ? 1'b0 : ack_ended_reg;
        flash_loaded   = flash_timer_reg;
        if (ack_detect)
        begin
            ack_seen_next = 1'b1;
            flash_loaded  = cfg.flash_length;
        end
        else if (ack_seen_next)
        begin
            ack_ended_next = 1'b1;
        end

        // short counter: saturates at timeout, then counts restore time
        short_inc = short_cnt_reg + 8'd1;
        if (over_current)
            short_cnt_next = (short_cnt_reg < tmo8) ? short_inc : tmo8;
        else if (short_cnt_reg >= tmo8)
            short_cnt_next = (short_inc >= {tmo, 1'b0}) ? 8'd0 : short_inc;
        else
            short_cnt_next = 8'd0;

        // tick dividers
        ms_inc    = {1'b0, ms_div_reg} + 5'd1;
        led_tick  = (ms_inc >= MS_PERIOD);
        ms_div_next = led_tick ? 4'd0 : ms_inc[3:0];

        flash_timer_next = flash_loaded;
        target_next      = target_reg;
        duty_next        = duty_reg;
        tenms_div_next   = tenms_div_reg;
        sec_next         = sec_reg;
        tenms_inc        = {1'b0, tenms_div_reg} + 8'd1;
        pulse            = 1'b0;
        if (led_tick)
        begin
            if (flash_loaded != 16'd0)
            begin
                flash_timer_next = flash_loaded - 16'd1;
                target_next = (flash_timer_next == 16'd0) ? cfg.dim_level : cfg.full_level;
            end
            if (duty_reg != {1'b0, target_next})
            begin
                if (duty_reg < {1'b0, target_next})
                    duty_next = duty_reg + 9'd2;
                else
                    duty_next = duty_reg - 9'd1;
            end
            if (tenms_inc >= TENMS_PERIOD)
            begin
                tenms_div_next = 7'd0;
                sec_next       = sec_reg + 16'd1;
                pulse          = 1'b1;
            end
            else
            begin
                tenms_div_next = tenms_inc[6:0];
            end
        end

        res_next.ack_flag          = ack_seen_next;
        res_next.ack_released_flag = ack_ended_next;
        res_next.output_enabled    = (short_cnt_next < tmo8);
        res_next.led_level         = duty_next;
        res_next.seconds           = sec_next;
        res_next.second_pulse      = pulse;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_timer_reg <= 16'd0;
            target_reg      <= 8'd16;
            duty_reg        <= 9'd0;
            ms_div_reg      <= 4'd0;
            tenms_div_reg   <= 7'd0;
            sec_reg         <= 16'd0;
            short_cnt_reg   <= 8'd0;
            ack_seen_reg    <= 1'b0;
            ack_ended_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                flash_timer_reg <= flash_timer_next;
                target_reg      <= target_next;
                duty_reg        <= duty_next;
                ms_div_reg      <= ms_div_next;
                tenms_div_reg   <= tenms_div_next;
                sec_reg         <= sec_next;
                short_cnt_reg   <= short_cnt_next;
                ack_seen_reg    <= ack_seen_next;
                ack_ended_reg   <= ack_ended_next;
                res_valid_reg   <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            res_reg <= res_next;
    end

endmodule

@@ rtl/core/track_current_supervisor_core.sv @@
// Track current supervisor top level: one tick request in, one status result out.
// Each tick request is held in an input register, the supervisor state (ack flags,
// short counter, LED ramp and dividers) is updated in one pass of short logic, and
// the status lands in a result register. A request is taken every clock cycle as
// long as the result side keeps up; the result is presented on m_tdata from the result
// register, after its request has passed through the input register.
// The single state update per tick sets that rate. Configuration writes are taken
// every cycle and should be issued only while no tick is in flight.
`timescale 1ns / 1ps

module track_current_supervisor_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // [15:0] current_sample, [27:16] sense_reading, [28] clear_ack, [31:29] zero
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tcs_pkg::IN_DATA_W-1:0]   s_tdata,
    // [0] ack_flag, [1] ack_released_flag, [2] output_enabled, [11:3] led_level,
    // [27:12] seconds, [28] second_pulse, [31:29] zero
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tcs_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tcs_pkg::*;

    cfg_t       cfg;
    tick_item_t item;
    logic       item_valid;
    logic       item_take;
    result_t    res;

    tcs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tcs_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    tcs_update u_update (
        .rst_n      (rst_n),
        .clk        (clk),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {3'b000, res};

endmodule
